// ----- rtl/core/qrs_pkg.sv -----
// qrs_pkg: shared widths and the per-stage payload type for the root solver.
// No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int DISC_W = 35;
  localparam int ROOT_W = 18;
  localparam int NUM_W  = 18;
  localparam int DEN_W  = 17;
  localparam int QUO_W  = 35;
  localparam int SQ_STEPS = 18;
  localparam int DV_STEPS = 35;

  typedef struct packed {
    logic              vld;
    logic              degen;
    logic              neg_disc;
    logic signed [15:0] b;
    logic [DEN_W-1:0]  den;
    logic              den_neg;
  } qrs_ctl_t;
endpackage

// ----- rtl/core/qrs_sqrt_cell.sv -----
// qrs_sqrt_cell: one registered step of the restoring integer square root.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  qrs_pkg::qrs_ctl_t          ctl_in,
  input  logic [qrs_pkg::DISC_W:0]   rem_in,
  input  logic [qrs_pkg::ROOT_W-1:0] root_in,
  input  logic [qrs_pkg::DISC_W:0]   rad_in,
  output qrs_pkg::qrs_ctl_t          ctl_out,
  output logic [qrs_pkg::DISC_W:0]   rem_out,
  output logic [qrs_pkg::ROOT_W-1:0] root_out,
  output logic [qrs_pkg::DISC_W:0]   rad_out
);
  import qrs_pkg::*;
  logic [DISC_W:0] rem_sh;
  logic [DISC_W:0] trial;
  logic            take;

  always_comb begin
    rem_sh = {rem_in[DISC_W-2:0], rad_in[DISC_W:DISC_W-1]};
    trial  = {{(DISC_W-ROOT_W-1){1'b0}}, root_in, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else begin
      ctl_out.vld <= ctl_in.vld;
    end
    ctl_out.degen    <= ctl_in.degen;
    ctl_out.neg_disc <= ctl_in.neg_disc;
    ctl_out.b        <= ctl_in.b;
    ctl_out.den      <= ctl_in.den;
    ctl_out.den_neg  <= ctl_in.den_neg;
    rem_out  <= take ? rem_sh - trial : rem_sh;
    root_out <= {root_in[ROOT_W-2:0], take};
    rad_out  <= {rad_in[DISC_W-2:0], 2'b00};
  end
endmodule

// ----- rtl/core/qrs_div_cell.sv -----
// qrs_div_cell: one registered restoring-division step for both roots.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  qrs_pkg::qrs_ctl_t         ctl_in,
  input  logic [1:0]                neg_in,
  input  logic [qrs_pkg::QUO_W-1:0] dvd_p_in,
  input  logic [qrs_pkg::QUO_W-1:0] dvd_m_in,
  input  logic [qrs_pkg::DEN_W:0]   rem_p_in,
  input  logic [qrs_pkg::DEN_W:0]   rem_m_in,
  output qrs_pkg::qrs_ctl_t         ctl_out,
  output logic [1:0]                neg_out,
  output logic [qrs_pkg::QUO_W-1:0] dvd_p_out,
  output logic [qrs_pkg::QUO_W-1:0] dvd_m_out,
  output logic [qrs_pkg::DEN_W:0]   rem_p_out,
  output logic [qrs_pkg::DEN_W:0]   rem_m_out
);
  import qrs_pkg::*;
  logic [DEN_W+1:0] sp, sm, dn;
  logic tp, tm;

  always_comb begin
    dn = {2'b00, ctl_in.den};
    sp = {rem_p_in, dvd_p_in[QUO_W-1]};
    sm = {rem_m_in, dvd_m_in[QUO_W-1]};
    tp = sp >= dn;
    tm = sm >= dn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else begin
      ctl_out.vld <= ctl_in.vld;
    end
    ctl_out.degen    <= ctl_in.degen;
    ctl_out.neg_disc <= ctl_in.neg_disc;
    ctl_out.b        <= ctl_in.b;
    ctl_out.den      <= ctl_in.den;
    ctl_out.den_neg  <= ctl_in.den_neg;
    neg_out   <= neg_in;
    rem_p_out <= tp ? (DEN_W+1)'(sp - dn) : (DEN_W+1)'(sp);
    rem_m_out <= tm ? (DEN_W+1)'(sm - dn) : (DEN_W+1)'(sm);
    dvd_p_out <= {dvd_p_in[QUO_W-2:0], tp};
    dvd_m_out <= {dvd_m_in[QUO_W-2:0], tm};
  end
endmodule

// ----- rtl/core/quadratic_root_solver.sv -----
// quadratic_root_solver: real roots of a*x^2+b*x+c in Q8.8 in, Q16.16 out.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
// Usage: drive coef_a/b/c and pulse start; busy is always low, so one
// transfer is taken on every cycle that start is high.
// Stage 0 registers the coefficients; stage 1 registers b*b and 4*a*c, giving
// D = b*b-4*a*c. A chain of 18 square-root cells then yields floor(sqrt(D)),
// one bit per cell. A chain of 35 division cells divides both numerators
// by |2a| in parallel, one quotient bit per cell. A final stage applies
// sign, saturation and the root count.
// A registered stage between the two chains forms both numerators.
// Throughput: one item per cycle; every cell holds a different item.
// done is high for exactly one cycle with the result; there is no stall.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coef_a,
  input  logic signed [15:0] coef_b,
  input  logic signed [15:0] coef_c,
  output logic               done,
  output logic signed [31:0] root_plus,
  output logic signed [31:0] root_minus,
  output logic [1:0]         root_count,
  output logic               degenerate,
  output logic               overflow
);
  import qrs_pkg::*;

  assign busy = 1'b0;

  logic s0_vld;
  logic signed [15:0] s0_a, s0_b, s0_c;
  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else s0_vld <= start;
    s0_a <= coef_a; s0_b <= coef_b; s0_c <= coef_c;
  end

  logic s1_vld;
  logic signed [31:0] s1_bb;
  logic signed [33:0] s1_ac4;
  logic signed [15:0] s1_a, s1_b;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else s1_vld <= s0_vld;
    s1_bb  <= s0_b * s0_b;
    s1_ac4 <= 34'(s0_a * s0_c) <<< 2;
    s1_a <= s0_a; s1_b <= s0_b;
  end

  logic signed [DISC_W-1:0] disc;
  logic signed [16:0] a2;
  qrs_ctl_t ctl0;
  always_comb begin
    disc = DISC_W'(s1_bb) - DISC_W'(s1_ac4);
    a2 = 17'(s1_a) <<< 1;
    ctl0.vld = s1_vld;
    ctl0.degen = s1_a == 16'sd0;
    ctl0.neg_disc = disc[DISC_W-1];
    ctl0.b = s1_b;
    ctl0.den_neg = a2[16];
    ctl0.den = a2[16] ? DEN_W'(-a2) : DEN_W'(a2);
  end

  qrs_ctl_t sq_ctl [SQ_STEPS+1];
  logic [DISC_W:0] sq_rem [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];
  logic [DISC_W:0] sq_rad [SQ_STEPS+1];
  assign sq_ctl[0] = ctl0;
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0] = disc[DISC_W-1] ? '0 : {1'b0, disc};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(sq_ctl[i]), .rem_in(sq_rem[i]), .root_in(sq_root[i]), .rad_in(sq_rad[i]),
      .ctl_out(sq_ctl[i+1]), .rem_out(sq_rem[i+1]), .root_out(sq_root[i+1]),
      .rad_out(sq_rad[i+1])
    );
  end

  qrs_ctl_t nm_ctl;
  logic [1:0] nm_neg;
  logic [NUM_W-1:0] nm_p, nm_m;
  logic signed [NUM_W:0] np, nmv;
  always_comb begin
    np  = -19'(sq_ctl[SQ_STEPS].b) + 19'($signed({1'b0, sq_root[SQ_STEPS]}));
    nmv = -19'(sq_ctl[SQ_STEPS].b) - 19'($signed({1'b0, sq_root[SQ_STEPS]}));
  end
  always_ff @(posedge clk) begin
    if (rst) nm_ctl.vld <= 1'b0;
    else nm_ctl.vld <= sq_ctl[SQ_STEPS].vld;
    nm_ctl.degen <= sq_ctl[SQ_STEPS].degen;
    nm_ctl.neg_disc <= sq_ctl[SQ_STEPS].neg_disc;
    nm_ctl.b <= sq_ctl[SQ_STEPS].b;
    nm_ctl.den <= sq_ctl[SQ_STEPS].den;
    nm_ctl.den_neg <= sq_ctl[SQ_STEPS].den_neg;
    nm_neg <= {np[NUM_W] ^ sq_ctl[SQ_STEPS].den_neg, nmv[NUM_W] ^ sq_ctl[SQ_STEPS].den_neg};
    nm_p <= np[NUM_W] ? NUM_W'(-np) : NUM_W'(np);
    nm_m <= nmv[NUM_W] ? NUM_W'(-nmv) : NUM_W'(nmv);
  end

  qrs_ctl_t dv_ctl [DV_STEPS+1];
  logic [1:0] dv_neg [DV_STEPS+1];
  logic [QUO_W-1:0] dv_p [DV_STEPS+1];
  logic [QUO_W-1:0] dv_m [DV_STEPS+1];
  logic [DEN_W:0] dv_rp [DV_STEPS+1];
  logic [DEN_W:0] dv_rm [DV_STEPS+1];
  assign dv_ctl[0] = nm_ctl;
  assign dv_neg[0] = nm_neg;
  assign dv_p[0] = {1'b0, nm_p, 16'h0000};
  assign dv_m[0] = {1'b0, nm_m, 16'h0000};
  assign dv_rp[0] = '0;
  assign dv_rm[0] = '0;

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(dv_ctl[j]), .neg_in(dv_neg[j]), .dvd_p_in(dv_p[j]), .dvd_m_in(dv_m[j]),
      .rem_p_in(dv_rp[j]), .rem_m_in(dv_rm[j]),
      .ctl_out(dv_ctl[j+1]), .neg_out(dv_neg[j+1]), .dvd_p_out(dv_p[j+1]),
      .dvd_m_out(dv_m[j+1]), .rem_p_out(dv_rp[j+1]), .rem_m_out(dv_rm[j+1])
    );
  end

  qrs_ctl_t fc;
  logic [QUO_W-1:0] qp, qm;
  logic signed [31:0] rp, rm;
  logic op, om, zero;
  always_comb begin
    fc = dv_ctl[DV_STEPS];
    qp = dv_p[DV_STEPS];
    qm = dv_m[DV_STEPS];
    zero = fc.degen || fc.neg_disc;
    if (dv_neg[DV_STEPS][1]) begin
      op = qp > QUO_W'(35'h080000000);
      rp = op ? 32'sh80000000 : -$signed(qp[31:0]);
    end else begin
      op = qp > QUO_W'(35'h07FFFFFFF);
      rp = op ? 32'sh7FFFFFFF : $signed(qp[31:0]);
    end
    if (dv_neg[DV_STEPS][0]) begin
      om = qm > QUO_W'(35'h080000000);
      rm = om ? 32'sh80000000 : -$signed(qm[31:0]);
    end else begin
      om = qm > QUO_W'(35'h07FFFFFFF);
      rm = om ? 32'sh7FFFFFFF : $signed(qm[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= fc.vld;
    root_plus  <= zero ? 32'sd0 : rp;
    root_minus <= zero ? 32'sd0 : rm;
    root_count <= zero ? 2'd0 : ((rp == rm) ? 2'd1 : 2'd2);
    degenerate <= fc.degen;
    overflow   <= zero ? 1'b0 : (op | om);
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) !busy) else $error("busy high");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s0_vld |-> ##56 done) else $error("latency");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> root_count == 2'd0 && !overflow) else $error("degenerate");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    done && root_count == 2'd1 |-> root_plus == root_minus) else $error("count");
`endif
endmodule

// ----- sim/quadratic_root_solver_tb.sv -----
// Testbench for quadratic_root_solver: drives Q8.8 coefficient sets and checks
// each root result against an in-bench fixed-point predictor.
// Depends on the quadratic_root_solver RTL only.
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;
  logic               done;
  logic signed [31:0] root_plus;
  logic signed [31:0] root_minus;
  logic [1:0]         root_count;
  logic               degenerate;
  logic               overflow;

  typedef struct packed {
    logic signed [31:0] rp;
    logic signed [31:0] rm;
    logic [1:0]         cnt;
    logic               degen;
    logic               ovf;
  } roots_t;

  roots_t roots_q[$];
  int     errors = 0;
  longint cycles = 0;
  localparam int LATENCY = 57;
  localparam longint LIMIT = 400000;

  quadratic_root_solver DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint floor_sqrt(longint n);
    longint r;
    longint bitv;
    r = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint q16_quotient(longint num, longint den, inout logic ovf);
    logic   neg;
    longint mn;
    longint md;
    longint q;
    neg = (num < 0) != (den < 0);
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn <<< 16) / md;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        ovf = 1;
        q = 64'h8000_0000;
      end
      return -q;
    end
    if (q > 64'h7FFF_FFFF) begin
      ovf = 1;
      q = 64'h7FFF_FFFF;
    end
    return q;
  endfunction

  function automatic roots_t predict_roots(logic signed [15:0] a, logic signed [15:0] b,
                                           logic signed [15:0] c);
    roots_t r;
    longint la, lb, lc, disc, s, p, m;
    logic   ovf;
    r = '0;
    ovf = 0;
    la = a;
    lb = b;
    lc = c;
    if (la == 0) begin
      r.degen = 1;
    end else begin
      disc = lb * lb - 4 * la * lc;
      if (disc >= 0) begin
        s = floor_sqrt(disc);
        p = q16_quotient(-lb + s, 2 * la, ovf);
        m = q16_quotient(-lb - s, 2 * la, ovf);
        r.rp = p[31:0];
        r.rm = m[31:0];
        r.cnt = (p == m) ? 2'd1 : 2'd2;
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    roots_q.push_back(predict_roots(a, b, c));
  endtask

  always @(posedge clk) begin
    roots_t e;
    if (!rst && done) begin
      if (roots_q.size() == 0) begin
        $display("%0t: result with no transfer pending", $time);
        errors++;
      end else begin
        e = roots_q.pop_front();
        if (root_plus !== e.rp) begin
          $display("%0t: root_plus exp %0d got %0d", $time, e.rp, root_plus);
          errors++;
        end
        if (root_minus !== e.rm) begin
          $display("%0t: root_minus exp %0d got %0d", $time, e.rm, root_minus);
          errors++;
        end
        if (root_count !== e.cnt) begin
          $display("%0t: root_count exp %0d got %0d", $time, e.cnt, root_count);
          errors++;
        end
        if (degenerate !== e.degen) begin
          $display("%0t: degenerate exp %0d got %0d", $time, e.degen, degenerate);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $display("%0t: overflow exp %0d got %0d", $time, e.ovf, overflow);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_coefs(16'sd0, 16'sd256, 16'sd256);
    send_coefs(16'sd0, 16'sd0, 16'sd0);
    send_coefs(16'sd256, 16'sd0, 16'sd256);
    send_coefs(16'sd256, -16'sd512, 16'sd256);
    send_coefs(16'sd256, 16'sd0, -16'sd1024);
    send_coefs(16'sd256, 16'sd0, 16'sd0);
    send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_coefs(-16'sh8000, -16'sh8000, -16'sh8000);
    send_coefs(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_coefs(16'sh7FFF, -16'sh8000, -16'sh8000);
    send_coefs(16'sd1, 16'sh7FFF, 16'sd0);
    send_coefs(16'sd1, -16'sh8000, 16'sd0);
    send_coefs(-16'sd1, 16'sh7FFF, -16'sh8000);
    send_coefs(16'sd1, 16'sd0, -16'sh8000);
    send_coefs(-16'sd1, 16'sd0, -16'sh8000);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(-16'sd256, 16'sd256, 16'sd512);
    send_coefs(16'sd3, 16'sd5, -16'sd7);
  endtask

  task automatic test_random();
    logic signed [15:0] a, b, c;
    int sel;
    repeat (1630) begin
      sel = $urandom_range(0, 9);
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      if (sel < 3) begin
        a = 16'($signed($urandom_range(0, 16)) - 8);
      end else if (sel < 5) begin
        c = 16'(-$signed({1'b0, a[14:0]}) * (a < 0 ? -1 : 1) / 4);
      end else if (sel == 5) begin
        a = 0;
      end else if (sel == 6) begin
        c = 0;
      end
      send_coefs(a, b, c);
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    coef_a = 0;
    coef_b = 0;
    coef_c = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random();
    start <= 0;
    while (roots_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
